>>> sv/decimal64_canonical_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the canonical decimal text formatter
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL64_CANONICAL_FORMATTER_ASSERT_SVH
`define DECIMAL64_CANONICAL_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define DCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DCF_ASSERT_SAME(lbl, ante, cons, msg)
`define DCF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Mode codes, character codes and widths of the canonical decimal formatter.
// ----------------------------------------------------------------------------
package dcf_pkg;

    // Mode codes of the op field.
    localparam logic [1:0] MODE_SIGNED   = 2'd0;
    localparam logic [1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [1:0] MODE_DEC64    = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Fraction digit limits.
    localparam logic [4:0] FRAC_MIN = 5'd1;
    localparam logic [4:0] FRAC_MAX = 5'd18;

    // Value and BCD widths.
    localparam int VALUE_W  = 64;
    localparam int DIGITS   = 20;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int STEP_W   = $clog2(VALUE_W);

    // ASCII characters.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage

>>> sv/decimal64_canonical_formatter.sv
// ----------------------------------------------------------------------------
// decimal64_canonical_formatter
// Turns a 64-bit value into its canonical decimal text, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) takes an item of op, raw_value and
//   frac_digits. Op selects signed integer, unsigned integer or decimal64
//   text; the unused op code is accepted and produces no characters.
//   The result channel (m_valid/m_ready) delivers the text one character
//   per item, with m_last_char high on the final character.
//   Sequence: load the item, run a 64-step shift-add-3 binary-to-BCD
//   conversion, locate the first and last digits, then emit one
//   character per cycle while the receiver is ready. A text holds at
//   most 21 characters; the 64-step conversion loop runs through the
//   single BCD adjust unit.
//   s_ready is high only while no item is in work; a new item may be taken
//   while the final character still waits in the output register.
//   A stalled receiver holds the current character and pauses the output.
//   Reset (aresetn low, synchronous) drops any item in work and clears
//   m_valid.
// ----------------------------------------------------------------------------
`include "decimal64_canonical_formatter_assert.svh"

module decimal64_canonical_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_raw_value,
    input  logic [4:0]  s_frac_digits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_text_char,
    output logic        m_last_char
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CONV  = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_DIGIT = 6'b010000,
        ST_POINT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [dcf_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [dcf_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [dcf_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic                        dec_reg, dec_next;
    logic [4:0]                  frac_reg, frac_next;
    logic [4:0]                  pos_reg, pos_next;
    logic [4:0]                  stop_reg, stop_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;

    logic                      accept;
    logic                      out_free;
    logic                      load;
    logic                      conv_done;
    logic [dcf_pkg::BCD_W-1:0] bcd_adj;
    logic [dcf_pkg::DIGITS-1:0] nz;
    logic [4:0]                hi_idx;
    logic [4:0]                lo_idx;
    logic [3:0]                cur_digit;
    logic                      in_neg;
    logic [4:0]                in_frac;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_text_char = char_reg;
    assign m_last_char = last_reg;

    // The final conversion step is under way.
    assign conv_done = (state_reg == ST_CONV) && (cnt_reg == {dcf_pkg::STEP_W{1'b1}});

    // Sign and fraction clamp of an incoming item.
    assign in_neg = ((s_op == dcf_pkg::MODE_SIGNED) || (s_op == dcf_pkg::MODE_DEC64))
                    && s_raw_value[dcf_pkg::VALUE_W-1];

    always_comb begin
        if (s_frac_digits < dcf_pkg::FRAC_MIN) begin
            in_frac = dcf_pkg::FRAC_MIN;
        end else if (s_frac_digits > dcf_pkg::FRAC_MAX) begin
            in_frac = dcf_pkg::FRAC_MAX;
        end else begin
            in_frac = s_frac_digits;
        end
    end

    // Shift-add-3 adjust: every BCD digit of five or more gets three added.
    always_comb begin
        for (int i = 0; i < dcf_pkg::DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Highest and lowest nonzero digit positions of the converted value.
    always_comb begin
        hi_idx = 5'd0;
        lo_idx = 5'd31;
        for (int i = 0; i < dcf_pkg::DIGITS; i++) begin
            nz[i] = (bcd_reg[4*i +: 4] != 4'd0);
        end
        for (int i = 0; i < dcf_pkg::DIGITS; i++) begin
            if (nz[i]) begin
                hi_idx = 5'(i);
            end
        end
        for (int i = dcf_pkg::DIGITS - 1; i >= 0; i--) begin
            if (nz[i]) begin
                lo_idx = 5'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[4*pos_reg +: 4];

    // Sequencer: load, convert, locate digits, then emit characters.
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        dec_next     = dec_reg;
        frac_next    = frac_reg;
        pos_next     = pos_reg;
        stop_next    = stop_reg;
        load         = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op != dcf_pkg::MODE_UNUSED)) begin
                    neg_next   = in_neg;
                    dec_next   = (s_op == dcf_pkg::MODE_DEC64);
                    frac_next  = in_frac;
                    mag_next   = in_neg ? (~s_raw_value + 64'd1) : s_raw_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = {bcd_adj[dcf_pkg::BCD_W-2:0], mag_reg[dcf_pkg::VALUE_W-1]};
                mag_next = {mag_reg[dcf_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (conv_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (dec_reg) begin
                    pos_next  = (hi_idx >= frac_reg) ? hi_idx : frac_reg;
                    stop_next = (lo_idx < frac_reg) ? lo_idx : (frac_reg - 5'd1);
                end else begin
                    pos_next  = hi_idx;
                    stop_next = 5'd0;
                end
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (out_free) begin
                    load       = 1'b1;
                    char_next  = dcf_pkg::CHAR_MINUS;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    load      = 1'b1;
                    char_next = dcf_pkg::CHAR_ZERO | {4'd0, cur_digit};
                    last_next = (pos_reg == stop_reg);
                    pos_next  = pos_reg - 5'd1;
                    if (pos_reg == stop_reg) begin
                        state_next = ST_IDLE;
                    end else if (dec_reg && (pos_reg == frac_reg)) begin
                        state_next = ST_POINT;
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    load       = 1'b1;
                    char_next  = dcf_pkg::CHAR_DOT;
                    state_next = ST_DIGIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: holds a character until the receiver takes it.
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        dec_reg  <= dec_next;
        frac_reg <= frac_next;
        pos_reg  <= pos_next;
        stop_reg <= stop_next;
        if (load) begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    // The emit position never runs below the last kept digit.
    `DCF_ASSERT_SAME(a_pos_above_stop, state_reg == ST_DIGIT, pos_reg >= stop_reg, "pos below stop")
    // A decimal point is only ever produced in decimal64 mode.
    `DCF_ASSERT_SAME(a_point_dec_only, state_reg == ST_POINT, dec_reg, "point outside decimal64")
    // Loading the final character returns the sequencer to idle.
    `DCF_ASSERT_NEXT(a_last_to_idle, load && last_next, state_reg == ST_IDLE, "last without idle")
    // The conversion runs exactly one step per value bit.
    `DCF_ASSERT_NEXT(a_conv_length, conv_done, state_reg == ST_PREP, "conversion length wrong")

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for decimal64_canonical_formatter
// Sends values in signed, unsigned and decimal64 modes (and the unused mode
// code) and checks each output character and its last flag against a text
// built independently in the bench. The sender works in bursts and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 420;
    localparam int SETTLE_CYCLES   = 120;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int REPORT_CAP      = 200;

    // One value to be formatted, plus a flag that holds it back until the
    // previous text has been fully received.
    typedef struct {
        logic [1:0]  op;
        logic [63:0] raw;
        logic [4:0]  frac;
        bit          wait_idle;
    } fmt_request_t;

    // One character of the expected text.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_HOLD,
        RX_TOGGLE
    } rx_pattern_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op          = dcf_pkg::MODE_SIGNED;
    logic [63:0] s_raw_value   = '0;
    logic [4:0]  s_frac_digits = dcf_pkg::FRAC_MIN;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_text_char;
    logic        m_last_char;

    fmt_request_t request_q[$];
    text_char_t   text_q[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           burst_left     = 4;
    int           gap_left       = 0;
    rx_pattern_t  rx_pattern     = RX_STREAM;
    int           rx_pattern_left = 40;

    decimal64_canonical_formatter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_raw_value   (s_raw_value),
        .s_frac_digits (s_frac_digits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_text_char   (m_text_char),
        .m_last_char   (m_last_char)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Build the canonical text of one value and queue its characters.
    function automatic void render_text(input logic [1:0] op, input logic [63:0] raw,
                                        input logic [4:0] frac);
        logic [7:0]  digs[20];
        logic [7:0]  rev[20];
        logic [7:0]  txt[$];
        logic [63:0] mag;
        logic [7:0]  c;
        logic        neg;
        int          nd;
        int          f;
        int          w;
        int          pad;
        int          intlen;
        int          keep;
        text_char_t  tc;

        if (op != dcf_pkg::MODE_SIGNED && op != dcf_pkg::MODE_UNSIGNED &&
            op != dcf_pkg::MODE_DEC64) begin
            return;
        end
        neg = (op != dcf_pkg::MODE_UNSIGNED) && raw[63];
        mag = neg ? (~raw + 64'd1) : raw;

        if (op == dcf_pkg::MODE_DEC64 && mag == 64'd0) begin
            txt = '{dcf_pkg::CHAR_ZERO, dcf_pkg::CHAR_DOT, dcf_pkg::CHAR_ZERO};
        end else begin
            // Decimal digits, most significant first.
            nd = 0;
            do begin
                rev[nd] = dcf_pkg::CHAR_ZERO + 8'(mag % 64'd10);
                mag = mag / 64'd10;
                nd++;
            end while (mag != 64'd0);
            for (int i = 0; i < nd; i++) begin
                digs[i] = rev[nd - 1 - i];
            end
            if (neg) begin
                txt.push_back(dcf_pkg::CHAR_MINUS);
            end
            if (op != dcf_pkg::MODE_DEC64) begin
                for (int i = 0; i < nd; i++) begin
                    txt.push_back(digs[i]);
                end
            end else begin
                // Zero-pad to frac+1 digits, then trim trailing fraction zeros.
                f = int'(frac);
                if (f < int'(dcf_pkg::FRAC_MIN)) f = int'(dcf_pkg::FRAC_MIN);
                if (f > int'(dcf_pkg::FRAC_MAX)) f = int'(dcf_pkg::FRAC_MAX);
                w = (nd > f + 1) ? nd : f + 1;
                pad = w - nd;
                intlen = w - f;
                keep = intlen;
                for (int p = intlen; p < w; p++) begin
                    c = (p < pad) ? dcf_pkg::CHAR_ZERO : digs[p - pad];
                    if (c != dcf_pkg::CHAR_ZERO) keep = p;
                end
                for (int p = 0; p <= keep; p++) begin
                    if (p == intlen) txt.push_back(dcf_pkg::CHAR_DOT);
                    txt.push_back((p < pad) ? dcf_pkg::CHAR_ZERO : digs[p - pad]);
                end
            end
        end

        foreach (txt[i]) begin
            tc.ch = txt[i];
            tc.last = (i == txt.size() - 1);
            text_q.push_back(tc);
        end
    endfunction

    task automatic add_request(input logic [1:0] op, input logic [63:0] raw,
                               input logic [4:0] frac, input bit wait_idle = 1'b0);
        fmt_request_t req;
        req.op = op;
        req.raw = raw;
        req.frac = frac;
        req.wait_idle = wait_idle;
        request_q.push_back(req);
    endtask

    // Random value, biased toward small numbers, boundaries and trailing zeros.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] scale;
        int          k;
        case ($urandom_range(0, 6))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: v = -64'($urandom_range(1, 999));
            3: begin
                scale = 64'd1;
                k = $urandom_range(0, 18);
                for (int i = 0; i < k; i++) scale = scale * 64'd10;
                v = 64'($urandom_range(1, 9)) * scale;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 64'd0;
                    1: v = 64'd1;
                    2: v = '1;
                    3: v = 64'h8000_0000_0000_0000;
                    default: v = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = -({$urandom, $urandom} >> $urandom_range(0, 63));
        endcase
        return v;
    endfunction

    // Sender: bursts of items separated by random gaps; some items wait
    // until every pending character has been received.
    always @(posedge aclk) begin : drive_requests
        fmt_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                render_text(s_op, s_raw_value, s_frac_digits);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].wait_idle &&
                              (text_q.size() != 0 || (s_valid && s_ready)))) begin
                    s_valid <= 1'b0;
                end else begin
                    req = request_q.pop_front();
                    s_op <= req.op;
                    s_raw_value <= req.raw;
                    s_frac_digits <= req.frac;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: switches between stall patterns after runs of random length.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_pattern_left == 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_pattern_left = $urandom_range(20, 200);
            end else begin
                rx_pattern_left--;
            end
            case (rx_pattern)
                RX_STREAM: m_ready <= 1'b1;
                RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_HOLD:   m_ready <= ($urandom_range(0, 7) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    // Compare every received character with the oldest expected one.
    always @(posedge aclk) begin : check_text
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (text_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP) begin
                    $display("%0t: unexpected character, expected none, got 0x%02h last %b",
                             $time, m_text_char, m_last_char);
                end
            end else begin
                want = text_q.pop_front();
                if (m_text_char !== want.ch) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP) begin
                        $display("%0t: text_char expected 0x%02h, got 0x%02h",
                                 $time, want.ch, m_text_char);
                    end
                end
                if (m_last_char !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP) begin
                        $display("%0t: last_char expected %b, got %b",
                                 $time, want.last, m_last_char);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [1:0] op;
        logic [4:0] frac;

        // Directed values: field extremes and each special case.
        add_request(dcf_pkg::MODE_SIGNED, 64'd0, 5'd1);
        add_request(dcf_pkg::MODE_SIGNED, 64'd1, 5'd0);
        add_request(dcf_pkg::MODE_SIGNED, '1, 5'd31);
        add_request(dcf_pkg::MODE_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 5'd18);
        add_request(dcf_pkg::MODE_SIGNED, 64'h8000_0000_0000_0000, 5'd5);
        add_request(dcf_pkg::MODE_SIGNED, 64'd12345, 5'd3);
        add_request(dcf_pkg::MODE_UNSIGNED, 64'd0, 5'd1);
        add_request(dcf_pkg::MODE_UNSIGNED, '1, 5'd0);
        add_request(dcf_pkg::MODE_UNSIGNED, 64'h8000_0000_0000_0000, 5'd31);
        add_request(dcf_pkg::MODE_UNSIGNED, 64'd10000000000000000000, 5'd18);
        add_request(dcf_pkg::MODE_UNSIGNED, 64'd9, 5'd2);
        add_request(dcf_pkg::MODE_DEC64, 64'd0, 5'd2);
        add_request(dcf_pkg::MODE_DEC64, 64'd1, 5'd1);
        add_request(dcf_pkg::MODE_DEC64, '1, 5'd18);
        add_request(dcf_pkg::MODE_DEC64, 64'h8000_0000_0000_0000, 5'd18);
        add_request(dcf_pkg::MODE_DEC64, 64'h7FFF_FFFF_FFFF_FFFF, 5'd1);
        add_request(dcf_pkg::MODE_DEC64, 64'd100, 5'd2);
        add_request(dcf_pkg::MODE_DEC64, 64'd120, 5'd2);
        add_request(dcf_pkg::MODE_DEC64, -64'd1234500, 5'd4);
        // Fraction count of zero behaves as one; large counts saturate.
        add_request(dcf_pkg::MODE_DEC64, 64'd5, 5'd0);
        add_request(dcf_pkg::MODE_DEC64, 64'd7, 5'd31);
        add_request(dcf_pkg::MODE_DEC64, -64'd3, 5'd19);
        add_request(dcf_pkg::MODE_DEC64, 64'd1000, 5'd3, 1'b1);
        // The unused mode code produces no text.
        add_request(dcf_pkg::MODE_UNUSED, {$urandom, $urandom}, 5'd31);
        add_request(dcf_pkg::MODE_SIGNED, -64'd42, 5'd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            op = ($urandom_range(0, 19) == 0) ? dcf_pkg::MODE_UNUSED
                                              : 2'($urandom_range(0, 2));
            frac = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 18));
            add_request(op, pick_value(), frac, $urandom_range(0, 49) == 0);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Check for completion away from the rising edge, once all updates
        // of that edge have settled.
        while (request_q.size() != 0 || s_valid || text_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && text_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/dcf_pkg.sv
sv/decimal64_canonical_formatter.sv
tb/sv/testbench.sv
